@@ hdl/wssm_pkg.sv @@
// Package for the working set size monitor: field widths, register reset values,
// register codes and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package wssm_pkg;

    // Field widths fixed by the item formats.
    localparam int ADDR_W      = 32;
    localparam int WSS_W       = 9;
    localparam int PSIZE_W     = 16;
    localparam int WSIZE_W     = 9;
    localparam int SCALE_SHIFT = 5;
    localparam int SCALED_W    = ADDR_W + SCALE_SHIFT;   // 37-bit dividend
    localparam int PAGE_W      = SCALED_W + 1;           // page number incl. the +1

    // APB side.
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // Register reset values.
    localparam logic [PSIZE_W-1:0] PAGE_SIZE_RST   = 16'd4096;
    localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST = 9'd16;

    // Default depth of the page store.
    localparam int MAX_WINDOW_DEF = 256;

    // Register index codes (word index in the APB map).
    typedef enum logic [0:0] {
        REG_PAGE_SIZE   = 1'b0,
        REG_WINDOW_SIZE = 1'b1
    } wssm_reg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the address, start the division
        logic div_step;     // one restoring division step
        logic search_init;  // rewind the page store search
        logic search_en;    // walk one page store entry
        logic update;       // store page, bump counters, close window if due
    } wssm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_done;  // search has a final hit/miss answer
        logic close;        // this item ends the window
    } wssm_sts_t;

endpackage

`default_nettype wire

@@ hdl/wssm_access_if.sv @@
// Input channel of the working set size monitor: one access address per item.
// Depends on wssm_pkg.
`default_nettype none

interface wssm_access_if;
    logic                        valid;
    logic                        ready;
    logic [wssm_pkg::ADDR_W-1:0] access_address;

    modport source (output valid, output access_address, input ready);
    modport sink   (input valid, input access_address, output ready);
endinterface

`default_nettype wire

@@ hdl/wssm_result_if.sv @@
// Output channel of the working set size monitor: one window result per item.
// Depends on wssm_pkg.
`default_nettype none

interface wssm_result_if;
    logic                       valid;
    logic                       ready;
    logic [wssm_pkg::WSS_W-1:0] working_set_size;

    modport source (output valid, output working_set_size, input ready);
    modport sink   (input valid, input working_set_size, output ready);
endinterface

`default_nettype wire

@@ hdl/wssm_ctrl.sv @@
// Controller of the working set size monitor: sequences division, page store
// search and update for one item, and owns the result valid flag. Depends on wssm_pkg.
`default_nettype none

module wssm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_ready,
    output logic                     out_valid,
    input  wire wssm_pkg::wssm_sts_t sts,
    output wssm_pkg::wssm_cmd_t      cmd
);
    import wssm_pkg::*;

    localparam int STEP_W = $clog2(SCALED_W);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(SCALED_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_UPDATE
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              result_blocked;

    // A finished window may not overwrite a result that is still waiting.
    assign result_blocked = sts.close && out_valid_reg && !out_ready;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST)
                begin
                    cmd.search_init = 1'b1;
                    state_next      = ST_SEARCH;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                cmd.search_en = 1'b1;
                if (sts.search_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (!result_blocked)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = (cmd.update && sts.close) || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

@@ hdl/wssm_dp.sv @@
// Datapath of the working set size monitor: bit-serial divider, page store memory
// with its search pointer, window counters and the result register. Depends on wssm_pkg.
`default_nettype none

module wssm_dp #(
    parameter int unsigned MAX_WINDOW = wssm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [wssm_pkg::ADDR_W-1:0]     access_address,
    input  wire logic [wssm_pkg::PSIZE_W-1:0]    page_size,
    input  wire logic [wssm_pkg::WSIZE_W-1:0]    window_size,
    input  wire wssm_pkg::wssm_cmd_t             cmd,
    output wssm_pkg::wssm_sts_t                  sts,
    output logic [wssm_pkg::WSS_W-1:0]           working_set_size
);
    import wssm_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    // Divider state: the quotient register starts as the scaled address and
    // shifts quotient bits in from the bottom.
    logic [SCALED_W-1:0] quo_reg, quo_next;
    logic [PSIZE_W-1:0]  rem_reg, rem_next;
    logic [PSIZE_W-1:0]  divisor;
    logic [PSIZE_W:0]    trial;
    logic [PSIZE_W:0]    diff;
    logic                q_bit;
    logic [PAGE_W-1:0]   page;

    // Search state.
    logic [PAGE_W-1:0]   store_mem [MAX_WINDOW];
    logic [PAGE_W-1:0]   rd_data_reg;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic                found_reg, found_next;
    logic                rd_issue;
    logic                match;

    // Window state.
    logic [CNT_W-1:0]    distinct_reg, distinct_next;
    logic [CNT_W-1:0]    access_reg, access_next;
    logic [WSS_W-1:0]    wss_reg;
    logic [CNT_W-1:0]    win_eff;
    logic                do_store;
    logic [CNT_W-1:0]    distinct_inc;
    logic [CNT_W:0]      access_inc;

    // ---------------- division ----------------
    assign divisor = (page_size == '0) ? PSIZE_W'(1) : page_size;
    assign trial   = {rem_reg, quo_reg[SCALED_W-1]};
    assign diff    = trial - {1'b0, divisor};
    assign q_bit   = (trial >= {1'b0, divisor});

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        if (cmd.load)
        begin
            quo_next = {access_address, SCALE_SHIFT'(0)};
            rem_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_next = {quo_reg[SCALED_W-2:0], q_bit};
            rem_next = q_bit ? diff[PSIZE_W-1:0] : trial[PSIZE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign page = PAGE_W'(quo_reg) + PAGE_W'(1);

    // ---------------- page store search ----------------
    assign rd_issue = cmd.search_en && (idx_reg < distinct_reg);
    assign match    = cmp_valid_reg && (rd_data_reg == page);

    always_comb
    begin
        idx_next       = idx_reg;
        cmp_valid_next = 1'b0;
        found_next     = found_reg;
        if (cmd.search_init)
        begin
            idx_next   = '0;
            found_next = 1'b0;
        end
        else if (cmd.search_en)
        begin
            cmp_valid_next = rd_issue;
            found_next     = found_reg || match;
            if (rd_issue)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_data_reg <= store_mem[idx_reg[AW-1:0]];
        end
        if (cmd.update && do_store)
        begin
            store_mem[distinct_reg[AW-1:0]] <= page;
        end
    end

    assign sts.search_done = found_reg || ((idx_reg >= distinct_reg) && !cmp_valid_reg);

    // ---------------- window bookkeeping ----------------
    always_comb
    begin
        if (window_size == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (32'(window_size) > 32'(MAX_WINDOW))
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(window_size);
        end
    end

    assign do_store     = !found_reg && (distinct_reg < win_eff)
                          && (32'(distinct_reg) < 32'(MAX_WINDOW));
    assign distinct_inc = distinct_reg + CNT_W'(do_store);
    assign access_inc   = {1'b0, access_reg} + (CNT_W + 1)'(1);
    assign sts.close    = (access_inc >= {1'b0, win_eff});

    always_comb
    begin
        distinct_next = distinct_reg;
        access_next   = access_reg;
        if (cmd.update)
        begin
            if (sts.close)
            begin
                distinct_next = '0;
                access_next   = '0;
            end
            else
            begin
                distinct_next = distinct_inc;
                access_next   = access_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distinct_reg <= '0;
            access_reg   <= '0;
        end
        else
        begin
            distinct_reg <= distinct_next;
            access_reg   <= access_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && sts.close)
        begin
            wss_reg <= WSS_W'(distinct_inc);
        end
    end

    assign working_set_size = wss_reg;

endmodule

`default_nettype wire

@@ hdl/working_set_size_monitor.sv @@
// Top level of the working set size monitor: APB configuration registers,
// controller and datapath instances, and assertions.
// Depends on wssm_pkg, wssm_access_if, wssm_result_if, wssm_ctrl and wssm_dp.
//
//   Channel   Kind          Payload                       Direction
//   access    valid/ready   access_address [31:0]         in
//   result    valid/ready   working_set_size [8:0]        out
//   APB       psel/penable  page_size @0x0, window_size @0x4  config
//
// One item: the idle state takes it, then 37 divider steps, the page store search and
// the update state; a new item is taken only once the last one is back in idle.
// rst_n, asynchronous and active low, clears the counters and the result flag.
// A waiting result stalls only an item that closes another window; that item holds
// in its update cycle until the older result is taken.
`default_nettype none

module working_set_size_monitor #(
    parameter int unsigned MAX_WINDOW = wssm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    wssm_access_if.sink                             access,
    wssm_result_if.source                           result,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [wssm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [wssm_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wssm_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                    pready
);
    import wssm_pkg::*;

    logic [PSIZE_W-1:0] page_size_reg, page_size_next;
    logic [WSIZE_W-1:0] window_size_reg, window_size_next;
    logic               cfg_write;
    wssm_reg_t          reg_sel;
    wssm_cmd_t          cmd;
    wssm_sts_t          sts;
    logic               in_ready;
    logic               out_valid;
    logic [WSS_W-1:0]   wss;

    // ------------------------------------------------------------------
    // Configuration registers. The word index is paddr[2]; writes complete in
    // the access phase and pready is tied high, so there are no wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = wssm_reg_t'(paddr[2]);

    always_comb
    begin
        page_size_next   = page_size_reg;
        window_size_next = window_size_reg;
        if (cfg_write)
        begin
            unique case (reg_sel)
                REG_PAGE_SIZE:   page_size_next   = pwdata[PSIZE_W-1:0];
                REG_WINDOW_SIZE: window_size_next = pwdata[WSIZE_W-1:0];
                default:         page_size_next   = page_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_reg   <= PAGE_SIZE_RST;
            window_size_reg <= WINDOW_SIZE_RST;
        end
        else
        begin
            page_size_reg   <= page_size_next;
            window_size_reg <= window_size_next;
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PAGE_SIZE:   prdata = APB_DATA_W'(page_size_reg);
            REG_WINDOW_SIZE: prdata = APB_DATA_W'(window_size_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: one item at a time through divide, search and update.
    // ------------------------------------------------------------------
    wssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (access.valid),
        .in_ready  (in_ready),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    // ------------------------------------------------------------------
    // Datapath: divider, page store and window counters.
    // ------------------------------------------------------------------
    wssm_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .access_address   (access.access_address),
        .page_size        (page_size_reg),
        .window_size      (window_size_reg),
        .cmd              (cmd),
        .sts              (sts),
        .working_set_size (wss)
    );

    assign access.ready            = in_ready;
    assign result.valid            = out_valid;
    assign result.working_set_size = wss;

`ifndef SYNTH
    // The block holds one item at a time: ready drops right after an acceptance.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (access.valid && access.ready) |=> !access.ready)
        else $error("access accepted while an item is still in progress");

    // Closing a window always presents a result in the next cycle.
    a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && sts.close) |=> result.valid)
        else $error("window closed without a result");

    // A closing update never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && sts.close) |-> !(result.valid && !result.ready))
        else $error("pending result overwritten");

    // Updates only happen once the search has settled.
    a_update_after_search: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> sts.search_done)
        else $error("update issued before the search finished");
`endif

endmodule

`default_nettype wire

@@ dv/wssm_window_checker.sv @@
// Checker for the working set size monitor: follows the APB register writes,
// predicts the window results from the accepted access items and compares them.
// Depends on wssm_pkg, wssm_access_if and wssm_result_if.
`default_nettype none

module wssm_window_checker #(
    parameter int unsigned MAX_WINDOW = wssm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    wssm_access_if                                  access,
    wssm_result_if                                  result,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic                               pready,
    input  wire logic [wssm_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [wssm_pkg::APB_DATA_W-1:0]    pwdata,
    output int                                      failures,
    output int                                      pending
);
    import wssm_pkg::*;

    logic [PSIZE_W-1:0] page_size_cfg;
    logic [WSIZE_W-1:0] window_size_cfg;
    logic [PAGE_W-1:0]  pages_seen [MAX_WINDOW];
    int                 distinct_pages;
    int                 accesses_in_window;
    int                 error_count;
    logic [WSS_W-1:0]   wss_expected [$];
    logic [WSS_W-1:0]   wss_want;

    // Page number of one access; the dividend keeps all 37 bits of the scaled address.
    function automatic logic [PAGE_W-1:0] page_number(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0] dividend;
        logic [PAGE_W-1:0] divisor;
        dividend = {1'b0, addr, {SCALE_SHIFT{1'b0}}};
        divisor  = (page_size_cfg == '0) ? PAGE_W'(1) : PAGE_W'(page_size_cfg);
        return dividend / divisor + PAGE_W'(1);
    endfunction

    // A window of zero means one access, and the window saturates at the store depth.
    function automatic int window_limit();
        int win;
        win = int'(window_size_cfg);
        if (win == 0)
        begin
            win = 1;
        end
        if (win > int'(MAX_WINDOW))
        begin
            win = int'(MAX_WINDOW);
        end
        return win;
    endfunction

    function automatic void count_access(input logic [ADDR_W-1:0] addr);
        logic [PAGE_W-1:0] page;
        int                win;
        int                i;
        bit                hit;
        page = page_number(addr);
        win  = window_limit();
        hit  = 1'b0;
        for (i = 0; i < distinct_pages && i < int'(MAX_WINDOW); i++)
        begin
            if (pages_seen[i] == page)
            begin
                hit = 1'b1;
            end
        end
        // After the window was lowered the set may already be full; a new page is dropped.
        if (!hit && distinct_pages < win && distinct_pages < int'(MAX_WINDOW))
        begin
            pages_seen[distinct_pages] = page;
            distinct_pages++;
        end
        accesses_in_window++;
        if (accesses_in_window >= win)
        begin
            wss_expected.push_back(WSS_W'(distinct_pages));
            distinct_pages     = 0;
            accesses_in_window = 0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_size_cfg      = PAGE_SIZE_RST;
            window_size_cfg    = WINDOW_SIZE_RST;
            distinct_pages     = 0;
            accesses_in_window = 0;
            error_count        = 0;
            wss_expected.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (wssm_reg_t'(paddr[APB_ADDR_W-1:2]))
                    REG_PAGE_SIZE:   page_size_cfg   = pwdata[PSIZE_W-1:0];
                    REG_WINDOW_SIZE: window_size_cfg = pwdata[WSIZE_W-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (wss_expected.size() == 0)
                begin
                    error_count++;
                    $display("%0t: working_set_size expected none, got %0d",
                             $time, result.working_set_size);
                end
                else
                begin
                    wss_want = wss_expected.pop_front();
                    if (wss_want !== result.working_set_size)
                    begin
                        error_count++;
                        $display("%0t: working_set_size expected %0d, got %0d",
                                 $time, wss_want, result.working_set_size);
                    end
                end
            end
            if (access.valid && access.ready)
            begin
                count_access(access.access_address);
            end
            failures <= error_count;
            pending  <= wss_expected.size();
        end
    end

endmodule

`default_nettype wire

@@ dv/tb_working_set_size_monitor.sv @@
// Testbench top for the working set size monitor: clock, reset, APB register
// writes, access stimulus, result backpressure, watchdog and the final verdict.
// Depends on wssm_pkg, wssm_access_if, wssm_result_if and wssm_window_checker.
`default_nettype none

module tb_working_set_size_monitor;
    import wssm_pkg::*;

    // One access runs the division and then searches up to every page store entry, so this
    // covers the slowest item with some margin before a register write.
    localparam int ITEM_LATENCY   = 41 + MAX_WINDOW_DEF + 24;
    // Quiet cycles tolerated: a long receiver hold plus a slow item, several times over.
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int HOLD_CYCLES    = 600;
    localparam int RANDOM_ITEMS   = 830;
    localparam int RECENT_DEPTH   = 8;

    // Traffic shapes on the two channels, cycled from one phase to the next.
    typedef enum logic [1:0] {
        TRAFFIC_FREE,
        TRAFFIC_SLOW_SOURCE,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_BOTH_SLOW
    } traffic_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int failures;
    int pending;
    int source_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    // Recently used addresses; reusing them makes windows with real page hits.
    logic [ADDR_W-1:0] recent_addrs [RECENT_DEPTH];

    wssm_access_if access_ch ();
    wssm_result_if result_ch ();

    working_set_size_monitor u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .access  (access_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    wssm_window_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .access   (access_ch),
        .result   (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The result side. Outside a hold it stalls at the rate of the current phase.
    // A hold is requested by bumping hold_requests and then counted out here, while
    // the access side keeps offering items, so the block fills up and stops taking them.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_served)
            begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // The watchdog restarts on every accepted item on either channel.
    always @(posedge clk)
    begin
        if ((access_ch.valid && access_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_working_set_size_monitor: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one access item after a random gap and returns at the edge that takes it.
    // valid stays high on return, so back-to-back items need no extra cycle.
    task automatic push_access(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = 0;
        while ($urandom_range(99) < source_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            access_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        access_ch.valid          <= 1'b1;
        access_ch.access_address <= addr;
        do
        begin
            @(posedge clk);
        end
        while (!access_ch.ready);
    endtask

    // Brings the block to rest: no more input, every predicted result delivered, and
    // time for an access that closes no window to finish its division and search.
    task automatic settle();
        access_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (ITEM_LATENCY) @(posedge clk);
    endtask

    // One APB write: setup cycle, access cycle, then the bus returns to idle.
    // Unused upper data bits are random.
    task automatic write_register(input wssm_reg_t which, input logic [PSIZE_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        if (which == REG_PAGE_SIZE)
        begin
            word[PSIZE_W-1:0] = value;
        end
        else
        begin
            word[WSIZE_W-1:0] = value[WSIZE_W-1:0];
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(which) * 4);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Both registers, in random order. A window left half full carries over.
    task automatic set_config(input logic [PSIZE_W-1:0] page, input logic [WSIZE_W-1:0] window);
        settle();
        if ($urandom_range(1) == 1)
        begin
            write_register(REG_PAGE_SIZE, page);
            write_register(REG_WINDOW_SIZE, PSIZE_W'(window));
        end
        else
        begin
            write_register(REG_WINDOW_SIZE, PSIZE_W'(window));
            write_register(REG_PAGE_SIZE, page);
        end
    endtask

    task automatic set_traffic(input traffic_t shape);
        case (shape)
            TRAFFIC_FREE:
            begin
                source_idle_pct = 0;
                sink_stall_pct  = 0;
            end
            TRAFFIC_SLOW_SOURCE:
            begin
                source_idle_pct = 70;
                sink_stall_pct  = 0;
            end
            TRAFFIC_SLOW_SINK:
            begin
                source_idle_pct = 0;
                sink_stall_pct  = 70;
            end
            default:
            begin
                source_idle_pct = 23;
                sink_stall_pct  = 23;
            end
        endcase
    endtask

    // Mostly repeats and near neighbors of recent addresses, so pages get hit again,
    // with fresh random addresses and the two extremes mixed in.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] addr;
        int                roll;
        roll = $urandom_range(99);
        if (roll < 50)
        begin
            addr = recent_addrs[$urandom_range(RECENT_DEPTH-1)];
        end
        else if (roll < 75)
        begin
            addr = recent_addrs[$urandom_range(RECENT_DEPTH-1)] + ADDR_W'($urandom_range(63));
        end
        else if (roll < 95)
        begin
            addr = $urandom;
        end
        else
        begin
            addr = ($urandom_range(1) == 1) ? '1 : '0;
        end
        if ($urandom_range(99) < 30)
        begin
            recent_addrs[$urandom_range(RECENT_DEPTH-1)] = addr;
        end
        return addr;
    endfunction

    // Page sizes: zero, one, the largest, powers of two and anything in between.
    function automatic logic [PSIZE_W-1:0] pick_page_size();
        int roll;
        roll = $urandom_range(5);
        if (roll == 0)
        begin
            return '0;
        end
        else if (roll == 1)
        begin
            return PSIZE_W'(1);
        end
        else if (roll == 2)
        begin
            return '1;
        end
        else if (roll == 3)
        begin
            return PSIZE_W'(1) << $urandom_range(PSIZE_W-1);
        end
        return PSIZE_W'($urandom_range(65535));
    endfunction

    // Windows stay short so that most items see several windows close.
    function automatic logic [WSIZE_W-1:0] pick_window();
        int roll;
        roll = $urandom_range(9);
        if (roll == 0)
        begin
            return '0;
        end
        else if (roll == 1)
        begin
            return WSIZE_W'(1);
        end
        else if (roll == 2)
        begin
            return WSIZE_W'($urandom_range(13, 40));
        end
        return WSIZE_W'($urandom_range(2, 12));
    endfunction

    initial
    begin
        int phase;
        int sent;
        int count;
        bit fresh;

        access_ch.valid          <= 1'b0;
        access_ch.access_address <= '0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        for (int i = 0; i < RECENT_DEPTH; i++)
        begin
            recent_addrs[i] = $urandom;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side.
        set_traffic(TRAFFIC_FREE);

        // Reset values: page size 4096 puts 128 word addresses in one page, so the first
        // two items share a page. The window of 16 is then lowered to 1 in the middle of
        // the window, and the next item closes it with the two pages collected so far.
        push_access(32'h0000_0000);
        push_access(32'h0000_007F);
        push_access(32'h0000_0080);
        set_config(PAGE_SIZE_RST, WSIZE_W'(1));
        push_access(32'h0000_0080);

        // Page size 1 with both address extremes: two pages in a window of four.
        set_config(PSIZE_W'(1), WSIZE_W'(4));
        push_access(32'h0000_0000);
        push_access(32'hFFFF_FFFF);
        push_access(32'h0000_0000);
        push_access(32'hFFFF_FFFF);

        // Page size zero acts as one, window zero as a single access.
        set_config('0, '0);
        push_access(32'hFFFF_FFFF);
        push_access(32'h0000_0000);

        // Largest page size: the first two addresses fall in the same page.
        set_config('1, WSIZE_W'(3));
        push_access(32'h0000_0000);
        push_access(32'h0000_07FF);
        push_access(32'hFFFF_FFFF);

        // Four distinct pages, then the window drops to 2: the set is already full, so
        // the fifth page is not stored and the window closes with four.
        set_config(PAGE_SIZE_RST, WSIZE_W'(6));
        push_access(32'h0000_0000);
        push_access(32'h0000_0080);
        push_access(32'h0000_0100);
        push_access(32'h0000_0180);
        set_config(PAGE_SIZE_RST, WSIZE_W'(2));
        push_access(32'h0000_0200);

        // Pressure: one result per item while the result side is held off for a long
        // stretch, so a second finished window backs up into the access channel.
        set_config(pick_page_size(), WSIZE_W'(1));
        hold_requests++;
        repeat (12) push_access(pick_address());

        // Random phases. Two of them use the largest windows: 256 exactly, with fresh
        // addresses at page size 1 so every page is new and the count reaches 256, and
        // 511, which saturates to 256.
        sent  = 12;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            fresh = 1'b0;
            if (phase == 2)
            begin
                set_config(PSIZE_W'(1), WSIZE_W'(MAX_WINDOW_DEF));
                count = MAX_WINDOW_DEF;
                fresh = 1'b1;
            end
            else if (phase == 5)
            begin
                set_config(pick_page_size(), '1);
                count = MAX_WINDOW_DEF;
            end
            else
            begin
                set_config(pick_page_size(), pick_window());
                count = $urandom_range(15, 50);
            end
            set_traffic(traffic_t'(phase % 4));
            repeat (count)
            begin
                push_access(fresh ? ADDR_W'($urandom) : pick_address());
                sent++;
            end
            phase++;
        end

        settle();
        if (failures == 0)
        begin
            $display("tb_working_set_size_monitor: done, clean");
        end
        else
        begin
            $display("tb_working_set_size_monitor: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hdl/wssm_pkg.sv
hdl/wssm_access_if.sv
hdl/wssm_result_if.sv
hdl/wssm_ctrl.sv
hdl/wssm_dp.sv
hdl/working_set_size_monitor.sv
dv/wssm_window_checker.sv
dv/tb_working_set_size_monitor.sv
